@@ sv/wfis_pkg.sv @@
// ----------------------------------------------------------------------------
// wfis_pkg
// Shared types, constants and the route table of the wire-follow sequencer.
// ----------------------------------------------------------------------------
package wfis_pkg;

    localparam int LEVEL_W  = 14;
    localparam int RUN_W    = 8;
    localparam int COOL_W   = 10;
    localparam int PATH_W   = 2;
    localparam int DUTY_W   = 7;
    localparam int INDEX_W  = 8;

    localparam int CROSSINGS_PER_ROUTE = 8;
    localparam int ROUTE_COUNT         = 3;
    localparam int ROM_ROWS            = 3;
    localparam int ROM_COLS            = 8;

    localparam logic [DUTY_W-1:0] PIVOT_DUTY = 7'd14;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST = 14'd2480;
    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST  = 14'd1240;
    localparam logic [LEVEL_W-1:0] DEADBAND_RST   = 14'd1091;
    localparam logic [RUN_W-1:0]   DEBOUNCE_RST   = 8'd1;
    localparam logic [COOL_W-1:0]  COOLDOWN_RST   = 10'd117;
    localparam logic [COOL_W-1:0]  LOCKOUT_RST    = 10'd67;
    localparam logic [PATH_W-1:0]  PATH_RST       = 2'd1;
    localparam logic [DUTY_W-1:0]  CRUISE_RST     = 7'd60;

    typedef enum logic [1:0] {
        ACT_FWD   = 2'd0,
        ACT_LEFT  = 2'd1,
        ACT_RIGHT = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_HIGH_LEVEL = 3'd0,
        REG_LOW_LEVEL  = 3'd1,
        REG_DEADBAND   = 3'd2,
        REG_DEBOUNCE   = 3'd3,
        REG_COOLDOWN   = 3'd4,
        REG_LOCKOUT    = 3'd5,
        REG_PATH       = 3'd6,
        REG_CRUISE     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] center_high_level;
        logic [LEVEL_W-1:0] center_low_level;
        logic [LEVEL_W-1:0] steer_deadband;
        logic [RUN_W-1:0]   debounce_samples;
        logic [COOL_W-1:0]  cooldown_samples;
        logic [COOL_W-1:0]  startup_lockout_samples;
        logic [PATH_W-1:0]  path_select;
        logic [DUTY_W-1:0]  cruise_speed;
    } cfg_t;

    typedef struct packed {
        logic               seen;
        action_t            action;
        logic [INDEX_W-1:0] done;
        logic               finished;
        logic               steer_en;
    } det_out_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              left_reverse;
        logic              right_reverse;
    } motor_t;

    localparam logic [1:0] ROUTE_ROM [ROM_ROWS][ROM_COLS] = '{
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0, 2'd3, 2'd3},
        '{2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3}
    };

    // Anything outside the stored table, or outside the route shape, means stop.
    function automatic action_t route_lookup(logic [PATH_W-1:0] row,
                                             logic [INDEX_W-1:0] col);
        action_t act;
        act = ACT_STOP;
        if (int'(row) < ROUTE_COUNT && int'(col) < CROSSINGS_PER_ROUTE &&
            int'(row) < ROM_ROWS && int'(col) < ROM_COLS)
        begin
            act = action_t'(ROUTE_ROM[row[1:0]][col[2:0]]);
        end
        return act;
    endfunction

endpackage

@@ sv/wfis_regs.sv @@
// ----------------------------------------------------------------------------
// wfis_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module wfis_regs
    import wfis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_high_level       <= HIGH_LEVEL_RST;
            cfg_reg.center_low_level        <= LOW_LEVEL_RST;
            cfg_reg.steer_deadband          <= DEADBAND_RST;
            cfg_reg.debounce_samples        <= DEBOUNCE_RST;
            cfg_reg.cooldown_samples        <= COOLDOWN_RST;
            cfg_reg.startup_lockout_samples <= LOCKOUT_RST;
            cfg_reg.path_select             <= PATH_RST;
            cfg_reg.cruise_speed            <= CRUISE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_HIGH_LEVEL: cfg_reg.center_high_level       <= pwdata[LEVEL_W-1:0];
                REG_LOW_LEVEL:  cfg_reg.center_low_level        <= pwdata[LEVEL_W-1:0];
                REG_DEADBAND:   cfg_reg.steer_deadband          <= pwdata[LEVEL_W-1:0];
                REG_DEBOUNCE:   cfg_reg.debounce_samples        <= pwdata[RUN_W-1:0];
                REG_COOLDOWN:   cfg_reg.cooldown_samples        <= pwdata[COOL_W-1:0];
                REG_LOCKOUT:    cfg_reg.startup_lockout_samples <= pwdata[COOL_W-1:0];
                REG_PATH:       cfg_reg.path_select             <= pwdata[PATH_W-1:0];
                REG_CRUISE:     cfg_reg.cruise_speed            <= pwdata[DUTY_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HIGH_LEVEL: prdata = 32'(cfg_reg.center_high_level);
            REG_LOW_LEVEL:  prdata = 32'(cfg_reg.center_low_level);
            REG_DEADBAND:   prdata = 32'(cfg_reg.steer_deadband);
            REG_DEBOUNCE:   prdata = 32'(cfg_reg.debounce_samples);
            REG_COOLDOWN:   prdata = 32'(cfg_reg.cooldown_samples);
            REG_LOCKOUT:    prdata = 32'(cfg_reg.startup_lockout_samples);
            REG_PATH:       prdata = 32'(cfg_reg.path_select);
            REG_CRUISE:     prdata = 32'(cfg_reg.cruise_speed);
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/wfis_detect.sv @@
// ----------------------------------------------------------------------------
// wfis_detect
// Cooldown timer, center-coil hysteresis detector and route sequencing.
// ----------------------------------------------------------------------------
module wfis_detect
    import wfis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [LEVEL_W-1:0] center_level,
    input  cfg_t               cfg,
    output det_out_t           det
);

    logic [COOL_W-1:0]  cooldown_reg, cooldown_next, cooldown_dec;
    logic               armed_reg, armed_next;
    logic [RUN_W-1:0]   high_run_reg, high_run_next, high_inc;
    logic [RUN_W-1:0]   low_run_reg, low_run_next, low_inc;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic               finished_reg, finished_next;
    logic               seen;
    action_t            act;

    assign cooldown_dec = (cooldown_reg != '0) ? cooldown_reg - 1'b1 : '0;
    assign high_inc     = (high_run_reg != '1) ? high_run_reg + 1'b1 : high_run_reg;
    assign low_inc      = (low_run_reg != '1) ? low_run_reg + 1'b1 : low_run_reg;

    always_comb
    begin
        cooldown_next = cooldown_dec;
        armed_next    = armed_reg;
        high_run_next = high_run_reg;
        low_run_next  = low_run_reg;
        index_next    = index_reg;
        finished_next = finished_reg;
        seen          = 1'b0;
        act           = ACT_FWD;
        if (!finished_reg)
        begin
            if (armed_reg)
            begin
                if (cooldown_dec == '0 && center_level > cfg.center_high_level)
                begin
                    high_run_next = high_inc;
                    low_run_next  = '0;
                    if (high_inc >= cfg.debounce_samples)
                    begin
                        armed_next    = 1'b0;
                        high_run_next = '0;
                        seen          = 1'b1;
                        act           = route_lookup(cfg.path_select, index_reg);
                        finished_next = (act == ACT_STOP);
                        if (index_reg != '1)
                        begin
                            index_next = index_reg + 1'b1;
                        end
                        cooldown_next = cfg.cooldown_samples;
                    end
                end
                else
                begin
                    high_run_next = '0;
                end
            end
            else
            begin
                if (center_level < cfg.center_low_level)
                begin
                    low_run_next = low_inc;
                    if (low_inc >= cfg.debounce_samples)
                    begin
                        armed_next   = 1'b1;
                        low_run_next = '0;
                    end
                end
                else
                begin
                    low_run_next = '0;
                end
            end
        end
    end

    assign det.seen     = seen;
    assign det.action   = act;
    assign det.done     = index_next;
    assign det.finished = finished_next;
    assign det.steer_en = !seen && !finished_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg <= LOCKOUT_RST;
            armed_reg    <= 1'b1;
            high_run_reg <= '0;
            low_run_reg  <= '0;
            index_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else if (advance)
        begin
            cooldown_reg <= cooldown_next;
            armed_reg    <= armed_next;
            high_run_reg <= high_run_next;
            low_run_reg  <= low_run_next;
            index_reg    <= index_next;
            finished_reg <= finished_next;
        end
    end

    // Once the route is finished it stays finished until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished state was left");

    // Each run counter only lives on its own side of the hysteresis.
    assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> high_run_reg == '0)
        else $error("high run counting while disarmed");

    assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> low_run_reg == '0)
        else $error("low run counting while armed");

    // The crossing count moves only on a confirmed crossing.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && seen) |=> $stable(index_reg))
        else $error("crossing count moved without a crossing");

endmodule

@@ sv/wfis_steer.sv @@
// ----------------------------------------------------------------------------
// wfis_steer
// Left-minus-right steering with a deadband and a trimmed right wheel.
// ----------------------------------------------------------------------------
module wfis_steer
    import wfis_pkg::*;
(
    input  logic [LEVEL_W-1:0] left_level,
    input  logic [LEVEL_W-1:0] right_level,
    input  cfg_t               cfg,
    input  logic               enable,
    output motor_t             motor
);

    logic signed [LEVEL_W+1:0] diff;
    logic signed [LEVEL_W+1:0] band;
    logic [DUTY_W-1:0]         cruise;
    logic [9:0]                scaled;
    logic [17:0]               recip;
    logic [DUTY_W-1:0]         trimmed;

    assign diff   = $signed({2'b00, left_level}) - $signed({2'b00, right_level});
    assign band   = $signed({2'b00, cfg.steer_deadband});
    assign cruise = (cfg.cruise_speed > DUTY_MAX) ? DUTY_MAX : cfg.cruise_speed;

    // 90 percent of cruise: times 9, then divide by 10 as times 205 over 2048,
    // which is exact for every value up to 900.
    assign scaled  = 10'(cruise) * 10'd9;
    assign recip   = 18'(scaled) * 18'd205;
    assign trimmed = recip[17:11];

    always_comb
    begin
        motor = '0;
        if (enable)
        begin
            priority if (diff > band)
            begin
                motor.left_reverse = 1'b1;
                motor.left_duty    = PIVOT_DUTY;
                motor.right_duty   = cruise;
            end
            else if (diff < -band)
            begin
                motor.right_reverse = 1'b1;
                motor.left_duty     = cruise;
                motor.right_duty    = PIVOT_DUTY;
            end
            else
            begin
                motor.left_duty  = cruise;
                motor.right_duty = trimmed;
            end
        end
    end

endmodule

@@ sv/wire_follow_intersection_sequencer.sv @@
// ----------------------------------------------------------------------------
// wire_follow_intersection_sequencer
// Coil-sample crossing detector, route sequencer and steering controller.
// ----------------------------------------------------------------------------
// Each word on the slave stream is one control-period sample of the left,
// right and center coils; each produces exactly one result word. A sample is
// captured in an input register, worked on combinationally, and lands in the
// result register, so the block takes one word per clock while the master
// side keeps taking results. The input register can hold one more sample
// while a result waits on the master side; then the input stalls. Configuration
// writes take effect on the next sample; a lockout write has no effect, as
// reset loads the fixed LOCKOUT_RST value into the cooldown.
module wire_follow_intersection_sequencer
    import wfis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // left_level[13:0], right_level[27:14],
                                   // center_level[41:28], zeros above
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // left_duty[6:0], right_duty[13:7],
                                   // left_reverse[14], right_reverse[15],
                                   // crossing_seen[16], crossing_action[18:17],
                                   // crossings_done[26:19], route_finished[27]
);

    localparam int RES_W = 2*DUTY_W + 3 + 2 + INDEX_W + 1;

    cfg_t               cfg;
    det_out_t           det;
    motor_t             motor;
    logic               in_valid_reg;
    logic [LEVEL_W-1:0] left_reg, right_reg, center_reg;
    logic               out_valid_reg;
    logic [RES_W-1:0]   out_reg, out_next;
    logic               advance;

    wfis_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sample moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    wfis_detect u_detect (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .center_level (center_reg),
        .cfg          (cfg),
        .det          (det)
    );

    wfis_steer u_steer (
        .left_level  (left_reg),
        .right_level (right_reg),
        .cfg         (cfg),
        .enable      (det.steer_en),
        .motor       (motor)
    );

    assign out_next = {det.finished, det.done, det.action, det.seen,
                       motor.right_reverse, motor.left_reverse,
                       motor.right_duty, motor.left_duty};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            left_reg   <= s_tdata[13:0];
            right_reg  <= s_tdata[27:14];
            center_reg <= s_tdata[41:28];
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(32-RES_W)'(0), out_reg};

    // A crossing sample leaves the motor fields to the turn sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("motor fields driven on a crossing sample");

    // A finished route keeps the motors off.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |-> m_tdata[15:0] == 16'd0)
        else $error("motors driven after the route finished");

    // With the result register empty the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wire-follow crossing sequencer.
// ----------------------------------------------------------------------------
// Coil samples go in on the slave stream and every result word is compared
// with a cycle-free model of the detector, route table and steering that is
// kept inside this file. A short table of hand-picked samples comes first,
// then phases of random samples under different register settings, with
// random stalls on both streams, one long output hold-off and one drain.
module tb_top
    import wfis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LEVEL_MAX      = 16383;

    // m_tdata layout, lowest bits last in the declaration.
    typedef struct packed {
        logic [3:0]         pad;
        logic               route_finished;
        logic [INDEX_W-1:0] crossings_done;
        action_t            crossing_action;
        logic               crossing_seen;
        logic               right_reverse;
        logic               left_reverse;
        logic [DUTY_W-1:0]  right_duty;
        logic [DUTY_W-1:0]  left_duty;
    } drive_result_t;

    typedef struct packed {
        int unsigned        repeats;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
        logic [LEVEL_W-1:0] center;
        logic               typed;
        drive_result_t      result;
    } sample_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    wire_follow_intersection_sequencer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow of the register file and of the sequencer state.
    cfg_t               shadow;
    logic [COOL_W-1:0]  cool_left;
    logic               armed;
    logic [RUN_W-1:0]   hi_run;
    logic [RUN_W-1:0]   lo_run;
    logic [INDEX_W-1:0] cross_idx;
    logic               route_done;

    drive_result_t pending_results[$];
    sample_row_t   directed_rows[$];
    int            center_plan[$];

    int  mismatch_count;
    int  samples_sent;
    int  words_checked;
    int  crossings_checked;
    int  settings_used;
    int  quiet_cycles;
    bit  rx_idle_on;
    bit  hold_req;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic drive_result_t result_of(int ld, int rd, bit lr, bit rr,
                                                bit seen, action_t act, int done,
                                                bit fin);
        drive_result_t res;
        res = '0;
        res.left_duty       = DUTY_W'(ld);
        res.right_duty      = DUTY_W'(rd);
        res.left_reverse    = lr;
        res.right_reverse   = rr;
        res.crossing_seen   = seen;
        res.crossing_action = act;
        res.crossings_done  = INDEX_W'(done);
        res.route_finished  = fin;
        return res;
    endfunction

    function automatic string describe(drive_result_t res);
        return $sformatf("duty %0d/%0d rev %0d/%0d seen %0d act %0d done %0d fin %0d pad %h",
                         res.left_duty, res.right_duty, res.left_reverse,
                         res.right_reverse, res.crossing_seen, res.crossing_action,
                         res.crossings_done, res.route_finished, res.pad);
    endfunction

    // One control period: cooldown, center-coil hysteresis, route lookup and
    // steering, in that order.
    function automatic drive_result_t steer_and_sequence(logic [LEVEL_W-1:0] l,
                                                         logic [LEVEL_W-1:0] r,
                                                         logic [LEVEL_W-1:0] c);
        drive_result_t res;
        action_t       act;
        int            cruise;
        int            diff;
        int            band;
        res    = '0;
        cruise = (int'(shadow.cruise_speed) > 100) ? 100 : int'(shadow.cruise_speed);
        if (cool_left != '0)
            cool_left = cool_left - 1'b1;

        if (!route_done)
        begin
            if (armed)
            begin
                if (cool_left == '0 && c > shadow.center_high_level)
                begin
                    if (hi_run != '1)
                        hi_run = hi_run + 1'b1;
                    lo_run = '0;
                    if (hi_run >= shadow.debounce_samples)
                    begin
                        armed  = 1'b0;
                        hi_run = '0;
                        act    = ACT_STOP;
                        if (int'(shadow.path_select) < ROUTE_COUNT &&
                            int'(cross_idx) < CROSSINGS_PER_ROUTE)
                        begin
                            act = action_t'(ROUTE_ROM[shadow.path_select][cross_idx[2:0]]);
                        end
                        res.crossing_seen   = 1'b1;
                        res.crossing_action = act;
                        if (act == ACT_STOP)
                            route_done = 1'b1;
                        if (cross_idx != '1)
                            cross_idx = cross_idx + 1'b1;
                        cool_left = shadow.cooldown_samples;
                    end
                end
                else
                begin
                    hi_run = '0;
                end
            end
            else
            begin
                if (c < shadow.center_low_level)
                begin
                    if (lo_run != '1)
                        lo_run = lo_run + 1'b1;
                    if (lo_run >= shadow.debounce_samples)
                    begin
                        armed  = 1'b1;
                        lo_run = '0;
                    end
                end
                else
                begin
                    lo_run = '0;
                end
            end

            if (!res.crossing_seen && !route_done)
            begin
                diff = int'(l) - int'(r);
                band = int'(shadow.steer_deadband);
                if (diff > band)
                begin
                    res.left_reverse = 1'b1;
                    res.left_duty    = PIVOT_DUTY;
                    res.right_duty   = DUTY_W'(cruise);
                end
                else if (diff < -band)
                begin
                    res.right_reverse = 1'b1;
                    res.left_duty     = DUTY_W'(cruise);
                    res.right_duty    = PIVOT_DUTY;
                end
                else
                begin
                    res.left_duty  = DUTY_W'(cruise);
                    res.right_duty = DUTY_W'((cruise * 90) / 100);
                end
            end
        end

        res.crossings_done = cross_idx;
        res.route_finished = route_done;
        return res;
    endfunction

    // APB write followed by a read-back of the same register.
    task automatic write_register(reg_idx_t idx, int unsigned value);
        logic [31:0] masked;
        logic [31:0] readback;
        case (idx)
            REG_HIGH_LEVEL:
            begin
                masked = value & 32'h3FFF;
                shadow.center_high_level = masked[LEVEL_W-1:0];
            end
            REG_LOW_LEVEL:
            begin
                masked = value & 32'h3FFF;
                shadow.center_low_level = masked[LEVEL_W-1:0];
            end
            REG_DEADBAND:
            begin
                masked = value & 32'h3FFF;
                shadow.steer_deadband = masked[LEVEL_W-1:0];
            end
            REG_DEBOUNCE:
            begin
                masked = value & 32'hFF;
                shadow.debounce_samples = masked[RUN_W-1:0];
            end
            REG_COOLDOWN:
            begin
                masked = value & 32'h3FF;
                shadow.cooldown_samples = masked[COOL_W-1:0];
            end
            REG_LOCKOUT:
            begin
                // Never loaded into the cooldown; reset uses LOCKOUT_RST instead.
                masked = value & 32'h3FF;
                shadow.startup_lockout_samples = masked[COOL_W-1:0];
            end
            REG_PATH:
            begin
                masked = value & 32'h3;
                shadow.path_select = masked[PATH_W-1:0];
            end
            default:
            begin
                masked = value & 32'h7F;
                shadow.cruise_speed = masked[DUTY_W-1:0];
            end
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== masked)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("register %s read back %h, expected %h", idx.name(), readback,
                         masked);
        end
    endtask

    task automatic apply_settings(int hi, int lo, int band, int deb, int cool, int lock,
                                  int path, int cruise);
        write_register(REG_HIGH_LEVEL, hi);
        write_register(REG_LOW_LEVEL, lo);
        write_register(REG_DEADBAND, band);
        write_register(REG_DEBOUNCE, deb);
        write_register(REG_COOLDOWN, cool);
        write_register(REG_LOCKOUT, lock);
        write_register(REG_PATH, path);
        write_register(REG_CRUISE, cruise);
        center_plan.delete();
        settings_used++;
    endtask

    // Offers one sample and holds it until the block takes it. The word is
    // predicted at the edge where it is accepted.
    task automatic send_sample(logic [LEVEL_W-1:0] l, logic [LEVEL_W-1:0] r,
                               logic [LEVEL_W-1:0] c, bit typed, drive_result_t typed_res);
        drive_result_t predicted;
        s_tdata  <= {6'b0, c, r, l};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predicted = steer_and_sequence(l, r, c);
        pending_results.push_back(typed ? typed_res : predicted);
        samples_sent++;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_row(int unsigned rep, int l, int r, int c, bit typed,
                           drive_result_t res);
        sample_row_t row;
        row.repeats = rep;
        row.left    = LEVEL_W'(l);
        row.right   = LEVEL_W'(r);
        row.center  = LEVEL_W'(c);
        row.typed   = typed;
        row.result  = res;
        directed_rows.push_back(row);
    endtask

    // Left and right codes: wide random spread, or a difference right at the
    // edge of the deadband, or a balanced pair.
    task automatic pick_coils(output logic [LEVEL_W-1:0] l, output logic [LEVEL_W-1:0] r);
        int lv;
        int rv;
        int delta;
        lv = $urandom_range(0, LEVEL_MAX);
        case ($urandom_range(0, 3))
            0, 1: rv = $urandom_range(0, LEVEL_MAX);
            2:
            begin
                delta = int'(shadow.steer_deadband) + $urandom_range(0, 2) - 1;
                rv    = $urandom_range(0, 1) ? lv - delta : lv + delta;
            end
            default: rv = lv;
        endcase
        if (rv < 0)
            rv = 0;
        if (rv > LEVEL_MAX)
            rv = LEVEL_MAX;
        l = LEVEL_W'(lv);
        r = LEVEL_W'(rv);
    endtask

    // Plans one stretch of center-coil samples. While more crossings are not
    // wanted, high runs stay shorter than the debounce count and every other
    // value is kept at or below the high threshold.
    task automatic plan_center(bit allow);
        int deb;
        int hi;
        int lo;
        int n;
        int v;
        deb = (shadow.debounce_samples == 0) ? 1 : int'(shadow.debounce_samples);
        hi  = int'(shadow.center_high_level);
        lo  = int'(shadow.center_low_level);
        case ($urandom_range(0, 3))
            0:
            begin
                n = 0;
                if (hi < LEVEL_MAX)
                begin
                    if (allow && $urandom_range(0, 1))
                        n = deb + $urandom_range(0, 2);
                    else if (deb > 1)
                        n = $urandom_range(1, (deb - 1 > 30) ? 30 : deb - 1);
                end
                repeat (n) center_plan.push_back($urandom_range(hi + 1, LEVEL_MAX));
                if (!allow)
                    center_plan.push_back(hi);
            end
            1:
            begin
                if (lo > 0)
                begin
                    n = $urandom_range(1, (deb + 2 > 32) ? 32 : deb + 2);
                    repeat (n)
                    begin
                        v = $urandom_range(0, lo - 1);
                        center_plan.push_back((!allow && v > hi) ? hi : v);
                    end
                end
            end
            2:
            begin
                if (lo <= hi)
                    repeat ($urandom_range(1, 4))
                        center_plan.push_back($urandom_range(lo, hi));
            end
            default: ;
        endcase
        if (center_plan.size() == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                v = $urandom_range(0, LEVEL_MAX);
                center_plan.push_back((!allow && v > hi) ? hi : v);
            end
        end
    endtask

    // Random samples; crossings are allowed only while the crossing count is
    // below crossing_cap, so the route does not finish early.
    task automatic run_phase(int count, int crossing_cap, bit idle_on);
        logic [LEVEL_W-1:0] l;
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] c;
        rx_idle_on = idle_on;
        for (int i = 0; i < count; i++)
        begin
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            if (center_plan.size() == 0)
                plan_center(int'(cross_idx) < crossing_cap);
            pick_coils(l, r);
            c = LEVEL_W'(center_plan.pop_front());
            send_sample(l, r, c, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        drive_result_t got;
        drive_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = drive_result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word with none pending: %s", describe(got));
            end
            else
            begin
                want = pending_results.pop_front();
                words_checked++;
                if (want.crossing_seen)
                    crossings_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d mismatch\n  expected %s\n  actual   %s",
                                 words_checked, describe(want), describe(got));
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no traffic for %0d cycles, %0d words pending",
                         quiet_cycles, pending_results.size());
                $display("wire_follow_intersection_sequencer test failed");
                $finish;
            end
        end
    end

    // Result-side ready: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int hi;
        mismatch_count    = 0;
        samples_sent      = 0;
        words_checked     = 0;
        crossings_checked = 0;
        settings_used     = 0;
        quiet_cycles      = 0;
        rx_idle_on        = 1'b1;
        hold_req          = 1'b0;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        shadow.center_high_level       = HIGH_LEVEL_RST;
        shadow.center_low_level        = LOW_LEVEL_RST;
        shadow.steer_deadband          = DEADBAND_RST;
        shadow.debounce_samples        = DEBOUNCE_RST;
        shadow.cooldown_samples        = COOLDOWN_RST;
        shadow.startup_lockout_samples = LOCKOUT_RST;
        shadow.path_select             = PATH_RST;
        shadow.cruise_speed            = CRUISE_RST;
        cool_left  = LOCKOUT_RST;
        armed      = 1'b1;
        hi_run     = '0;
        lo_run     = '0;
        cross_idx  = '0;
        route_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No cooldown after a crossing, so the table can take crossings back
        // to back. The lockout write must not restart the startup cooldown.
        write_register(REG_COOLDOWN, 0);
        write_register(REG_LOCKOUT, 1023);

        // Reset thresholds: high 2480, low 1240, deadband 1091, cruise 60.
        add_row(1, 0, 0, 0, 1, result_of(60, 54, 0, 0, 0, ACT_FWD, 0, 0));
        add_row(1, LEVEL_MAX, 0, LEVEL_MAX, 1,
                result_of(14, 60, 1, 0, 0, ACT_FWD, 0, 0));
        add_row(1, 0, LEVEL_MAX, LEVEL_MAX, 1,
                result_of(60, 14, 0, 1, 0, ACT_FWD, 0, 0));
        add_row(1, 1091, 0, 0, 1, result_of(60, 54, 0, 0, 0, ACT_FWD, 0, 0));
        add_row(1, 1092, 0, 0, 1, result_of(14, 60, 1, 0, 0, ACT_FWD, 0, 0));
        add_row(1, 0, 1091, 0, 1, result_of(60, 54, 0, 0, 0, ACT_FWD, 0, 0));
        add_row(1, 0, 1092, 0, 1, result_of(60, 14, 0, 1, 0, ACT_FWD, 0, 0));
        // A center spike while the startup lockout runs is ignored.
        add_row(1, LEVEL_MAX, LEVEL_MAX, 2481, 1,
                result_of(60, 54, 0, 0, 0, ACT_FWD, 0, 0));
        // Quiet samples until the lockout has run out.
        add_row(58, 0, 0, 0, 0, '0);
        add_row(1, 0, 0, 2480, 0, '0);
        add_row(1, 0, 0, 2481, 1, result_of(0, 0, 0, 0, 1, ACT_LEFT, 1, 0));
        add_row(1, LEVEL_MAX, 0, LEVEL_MAX, 0, '0);
        add_row(1, 0, 0, 1240, 0, '0);
        add_row(1, 0, 0, 1239, 0, '0);
        add_row(1, 0, 0, LEVEL_MAX, 1, result_of(0, 0, 0, 0, 1, ACT_RIGHT, 2, 0));
        add_row(1, 5461, 10922, 0, 0, '0);

        foreach (directed_rows[i])
            repeat (directed_rows[i].repeats)
                send_sample(directed_rows[i].left, directed_rows[i].right,
                            directed_rows[i].center, directed_rows[i].typed,
                            directed_rows[i].result);
        s_tvalid <= 1'b0;
        wait_for_results();

        hi = $urandom_range(1500, 14000);
        apply_settings(hi, $urandom_range(0, hi), $urandom_range(0, 4000),
                       $urandom_range(2, 12), $urandom_range(0, 300),
                       $urandom_range(0, 1023), $urandom_range(0, 2),
                       $urandom_range(0, 100));
        run_phase(100, 3, 1);
        wait_for_results();

        // Upper extremes: nothing can cross, zero deadband, cruise capped.
        apply_settings(LEVEL_MAX, 0, 0, 255, 1023, 0, 2, 127);
        run_phase(40, 0, 1);
        wait_for_results();

        // Lower extremes: zero debounce acts as one, band swallows all steering.
        apply_settings(0, LEVEL_MAX, LEVEL_MAX, 0, 0, 1023, 0, 0);
        run_phase(70, 5, 0);
        wait_for_results();

        hi = $urandom_range(1000, 15000);
        apply_settings(hi, $urandom_range(0, hi), $urandom_range(0, 3000),
                       $urandom_range(1, 6), $urandom_range(0, 40),
                       $urandom_range(0, 1023), $urandom_range(0, 2),
                       $urandom_range(0, 127));
        run_phase(80, 6, 1);
        // Long output hold-off while samples keep coming, so the input stalls.
        hold_req = 1'b1;
        run_phase(50, 6, 0);
        wait_for_results();
        run_phase(80, 6, 1);
        wait_for_results();

        // A route row past the table makes the next crossing a stop.
        apply_settings(3000, 1000, $urandom_range(0, 2000), $urandom_range(1, 3),
                       $urandom_range(0, 5), 67, 3, $urandom_range(0, 100));
        run_phase(20, 256, 1);
        run_phase(40, 256, 0);

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d samples under %0d register settings; %0d words checked.",
                 samples_sent, settings_used + 1, words_checked);
        $display("Crossings confirmed: %0d, route finished: %0d, failures: %0d.",
                 crossings_checked, route_done, mismatch_count);
        if (mismatch_count == 0)
            $display("wire_follow_intersection_sequencer test passed");
        else
            $display("wire_follow_intersection_sequencer test failed");
        $finish;
    end

endmodule
